/* hw/rtl/bounded_list_engine_macros.svh */
// assertion macros for the bounded list engine checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef BOUNDED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_LIST_ENGINE_MACROS_SVH

// consequent checked in the same cycle
`define BLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define BLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ble_pkg.sv */
// shared types and codes for the bounded list engine
// no dependencies
package ble_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int VALUE_W  = 32;
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 7;
  localparam int KIND_W   = 3;
  localparam int S_DATA_W = 40;  // value + position, padded to bytes
  localparam int M_DATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEDUPE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PAL    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SHOW   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_REMOVED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NOTFOUND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ELEMENT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PAL_YES  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PAL_NO   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd6;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [KIND_W-1:0]         kind;
    logic                      last;
  } res_t;

endpackage

/* hw/rtl/ble_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module ble_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ble_seq.sv */
// command sequencer: walks the element ram one access a cycle at most, held
// on result ready, with a shared equality compare; depends on ble_pkg
module ble_seq #(
  parameter int CAPACITY = ble_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  output logic                              cmd_ready_o,
  input  logic [ble_pkg::FUNC_W-1:0]        cmd_func_i,
  input  logic [ble_pkg::VALUE_W-1:0]       cmd_value_i,
  input  logic [ble_pkg::POS_W-1:0]         cmd_pos_i,
  output logic                              ram_we_o,
  output logic [$clog2(CAPACITY)-1:0]       ram_waddr_o,
  output logic [ble_pkg::VALUE_W-1:0]       ram_wdata_o,
  output logic                              ram_re_o,
  output logic [$clog2(CAPACITY)-1:0]       ram_raddr_o,
  input  logic [ble_pkg::VALUE_W-1:0]       ram_rdata_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output ble_pkg::res_t                     res_o
);

  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RM_CAP = 4'd1;
  localparam logic [3:0] S_RM_RD  = 4'd2;
  localparam logic [3:0] S_RM_WR  = 4'd3;
  localparam logic [3:0] S_DD_RD  = 4'd4;
  localparam logic [3:0] S_DD_CAP = 4'd5;
  localparam logic [3:0] S_DD_KRD = 4'd6;
  localparam logic [3:0] S_DD_CMP = 4'd7;
  localparam logic [3:0] S_PL_RD  = 4'd8;
  localparam logic [3:0] S_PL_CAP = 4'd9;
  localparam logic [3:0] S_PL_CMP = 4'd10;
  localparam logic [3:0] S_LS_CHK = 4'd11;
  localparam logic [3:0] S_LS_RD  = 4'd12;
  localparam logic [3:0] S_LS_OUT = 4'd13;
  localparam logic [3:0] S_EMIT   = 4'd14;

  logic [3:0]                   state_q, state_d;
  logic [LEN_W-1:0]             len_q, len_d;
  logic [LEN_W-1:0]             i_q, i_d;   // read index
  logic [LEN_W-1:0]             j_q, j_d;   // dedupe write index
  logic [LEN_W-1:0]             k_q, k_d;   // dedupe scan index
  logic [ble_pkg::VALUE_W-1:0]  cur_q, cur_d;
  logic [ble_pkg::KIND_W-1:0]   rkind_q, rkind_d;
  logic [ble_pkg::VALUE_W-1:0]  rval_q, rval_d;

  logic                         eq;
  logic                         pos_bad;
  logic [ble_pkg::POS_W-1:0]    pos_m1;
  logic [LEN_W-1:0]             i_inc;
  logic [LEN_W-1:0]             mirror;
  logic                         full;

  // the one shared compare unit
  assign eq      = (ram_rdata_i == cur_q);
  assign pos_m1  = cmd_pos_i - ble_pkg::POS_W'(1);
  assign pos_bad = (cmd_pos_i == '0) || (cmd_pos_i > ble_pkg::POS_W'(len_q));
  assign i_inc   = i_q + LEN_W'(1);
  assign mirror  = len_q - LEN_W'(1) - i_q;
  assign full    = (len_q == LEN_W'(CAPACITY));

  assign cmd_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    cur_d       = cur_q;
    rkind_d     = rkind_q;
    rval_d      = rval_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = i_q[ADDR_W-1:0];
    ram_wdata_o = cur_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = i_q[ADDR_W-1:0];
    res_valid_o = 1'b0;
    res_o       = '{value: rval_q, kind: rkind_q, last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_func_i)
            ble_pkg::FUNC_APPEND: begin
              if (full) begin
                rkind_d = ble_pkg::KIND_FULL;
                rval_d  = '0;
                state_d = S_EMIT;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = len_q[ADDR_W-1:0];
                ram_wdata_o = cmd_value_i;
                len_d       = len_q + LEN_W'(1);
              end
            end
            ble_pkg::FUNC_REMOVE: begin
              if (pos_bad) begin
                rkind_d = ble_pkg::KIND_NOTFOUND;
                rval_d  = '0;
                state_d = S_EMIT;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = pos_m1[ADDR_W-1:0];
                i_d         = pos_m1[LEN_W-1:0];
                state_d     = S_RM_CAP;
              end
            end
            ble_pkg::FUNC_DEDUPE: begin
              i_d     = '0;
              j_d     = '0;
              state_d = S_DD_RD;
            end
            ble_pkg::FUNC_PAL: begin
              i_d     = '0;
              state_d = S_PL_RD;
            end
            ble_pkg::FUNC_SHOW: begin
              state_d = S_LS_CHK;
            end
            default: begin
            end
          endcase
        end
      end
      S_RM_CAP: begin
        rval_d  = ram_rdata_i;
        state_d = S_RM_RD;
      end
      // close the gap one entry at a time
      S_RM_RD: begin
        if (i_inc < len_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = i_inc[ADDR_W-1:0];
          state_d     = S_RM_WR;
        end else begin
          len_d   = len_q - LEN_W'(1);
          rkind_d = ble_pkg::KIND_REMOVED;
          state_d = S_EMIT;
        end
      end
      S_RM_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = i_q[ADDR_W-1:0];
        ram_wdata_o = ram_rdata_i;
        i_d         = i_inc;
        state_d     = S_RM_RD;
      end
      S_DD_RD: begin
        if (i_q < len_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = i_q[ADDR_W-1:0];
          state_d     = S_DD_CAP;
        end else begin
          len_d   = j_q;
          state_d = S_LS_CHK;
        end
      end
      S_DD_CAP: begin
        cur_d   = ram_rdata_i;
        k_d     = '0;
        state_d = S_DD_KRD;
      end
      // scan the kept prefix for a copy of cur
      S_DD_KRD: begin
        if (k_q < j_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = k_q[ADDR_W-1:0];
          state_d     = S_DD_CMP;
        end else begin
          ram_we_o    = 1'b1;
          ram_waddr_o = j_q[ADDR_W-1:0];
          ram_wdata_o = cur_q;
          j_d         = j_q + LEN_W'(1);
          i_d         = i_inc;
          state_d     = S_DD_RD;
        end
      end
      S_DD_CMP: begin
        if (eq) begin
          i_d     = i_inc;
          state_d = S_DD_RD;
        end else begin
          k_d     = k_q + LEN_W'(1);
          state_d = S_DD_KRD;
        end
      end
      S_PL_RD: begin
        if (i_q < (len_q >> 1)) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = i_q[ADDR_W-1:0];
          state_d     = S_PL_CAP;
        end else begin
          rkind_d = ble_pkg::KIND_PAL_YES;
          rval_d  = '0;
          state_d = S_EMIT;
        end
      end
      S_PL_CAP: begin
        cur_d       = ram_rdata_i;
        ram_re_o    = 1'b1;
        ram_raddr_o = mirror[ADDR_W-1:0];
        state_d     = S_PL_CMP;
      end
      S_PL_CMP: begin
        if (eq) begin
          i_d     = i_inc;
          state_d = S_PL_RD;
        end else begin
          rkind_d = ble_pkg::KIND_PAL_NO;
          rval_d  = '0;
          state_d = S_EMIT;
        end
      end
      S_LS_CHK: begin
        if (len_q == '0) begin
          rkind_d = ble_pkg::KIND_EMPTY;
          rval_d  = '0;
          state_d = S_EMIT;
        end else begin
          i_d     = '0;
          state_d = S_LS_RD;
        end
      end
      S_LS_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = i_q[ADDR_W-1:0];
        state_d     = S_LS_OUT;
      end
      // ram read data holds until the next read, so it can wait on ready
      S_LS_OUT: begin
        res_valid_o = 1'b1;
        res_o       = '{value: ram_rdata_i, kind: ble_pkg::KIND_ELEMENT,
                        last: (i_inc == len_q)};
        if (res_ready_i) begin
          if (i_inc == len_q) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_inc;
            state_d = S_LS_RD;
          end
        end
      end
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    rkind_q <= rkind_d;
    rval_q  <= rval_d;
  end

endmodule

/* hw/rtl/ble_out_stage.sv */
// output register between the sequencer and the result stream
// depends on ble_pkg
module ble_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  output logic          res_ready_o,
  input  ble_pkg::res_t res_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ble_pkg::res_t out_o
);

  logic          valid_q, valid_d;
  ble_pkg::res_t data_q;
  logic          load;

  // take a new request whenever the slot is empty or draining this cycle
  assign res_ready_o = !valid_q || out_ready_i;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

/* hw/rtl/bounded_list_engine.sv */
// bounded list engine top level: command stream in, result stream out
// depends on ble_pkg, ble_seq, ble_ram, ble_out_stage
//
//  channel  dir  tdata                        tuser        tlast
//  s_axis   in   value[31:0] position[38:32]  func[2:0]    -
//  m_axis   out  value_out[31:0]              kind[2:0]    last
//
// append writes from idle and gives no result, or a full result when full;
// remove shifts each later entry down; palindrome compares mirrored pairs,
// show emits each element; dedupe compares each element against the kept
// prefix; all walks go through the single ram port and the one shared
// comparator
// s_axis_tready is low while a command runs; results stall on m_axis_tready
// reset clears the length; ram contents are not cleared
module bounded_list_engine #(
  parameter int CAPACITY = ble_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ble_pkg::S_DATA_W-1:0]  s_axis_tdata,  // value[31:0], position[38:32]
  input  logic [ble_pkg::FUNC_W-1:0]    s_axis_tuser,  // func[2:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ble_pkg::M_DATA_W-1:0]  m_axis_tdata,  // value_out[31:0]
  output logic [ble_pkg::KIND_W-1:0]    m_axis_tuser,  // kind[2:0]
  output logic                          m_axis_tlast
);

  localparam int ADDR_W = $clog2(CAPACITY);

  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [ble_pkg::VALUE_W-1:0]  ram_wdata;
  logic                         ram_re;
  logic [ADDR_W-1:0]            ram_raddr;
  logic [ble_pkg::VALUE_W-1:0]  ram_rdata;
  logic                         res_valid;
  logic                         res_ready;
  ble_pkg::res_t                res;
  ble_pkg::res_t                out;

  ble_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_func_i  (s_axis_tuser),
    .cmd_value_i (s_axis_tdata[ble_pkg::VALUE_W-1:0]),
    .cmd_pos_i   (s_axis_tdata[ble_pkg::VALUE_W +: ble_pkg::POS_W]),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ble_ram #(
    .WIDTH(ble_pkg::VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ble_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  assign m_axis_tdata = out.value;
  assign m_axis_tuser = out.kind;
  assign m_axis_tlast = out.last;

endmodule

/* hw/rtl/ble_chk.sv */
// port level checks for the bounded list engine, bound to the top level
// depends on ble_pkg and bounded_list_engine_macros.svh
`include "bounded_list_engine_macros.svh"

module ble_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [ble_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input logic [ble_pkg::FUNC_W-1:0]    s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ble_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input logic [ble_pkg::KIND_W-1:0]    m_axis_tuser,
  input logic                          m_axis_tlast
);

  logic s_req;
  logic m_single;

  assign s_req    = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);
  // every kind but element closes its command with one result
  assign m_single = m_axis_tvalid && (m_axis_tuser != ble_pkg::KIND_ELEMENT);

  `BLE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  `BLE_ASSERT_NEXT(a_busy_after_cmd, s_req && (s_axis_tuser == ble_pkg::FUNC_REMOVE || s_axis_tuser == ble_pkg::FUNC_DEDUPE || s_axis_tuser == ble_pkg::FUNC_PAL || s_axis_tuser == ble_pkg::FUNC_SHOW), !s_axis_tready, "ready while a command runs")

  `BLE_ASSERT_NOW(a_single_last, m_single, m_axis_tlast, "single result without last")

  `BLE_ASSERT_NOW(a_status_zero, m_single && m_axis_tuser != ble_pkg::KIND_REMOVED, m_axis_tdata == '0, "status result with nonzero value")

endmodule

bind bounded_list_engine ble_chk u_ble_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
